FILE: hdl/affine_point_delta_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine point delta decoder
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_POINT_DELTA_DECODER_UNIT_DEFINES_SVH
`define AFFINE_POINT_DELTA_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication
`define APDD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define APDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/apdd_pkg.sv
// ----------------------------------------------------------------------------
// apdd_pkg
// Shared types and constants of the affine point delta decoder.
// ----------------------------------------------------------------------------
package apdd_pkg;

    localparam int MAX_POINTS_DEF = 255;
    localparam int MFB_DEF        = 30;

    localparam int POS_W   = 32;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int SUM_W   = 40;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 65;
    localparam int RP_W    = 50;
    localparam int ACC_W   = 52;
    localparam int DVD_W   = 41;
    localparam int REM_W   = 10;
    localparam int STEP_W  = 6;
    localparam int STORE_DEPTH = 256;
    localparam int STORE_W = 3 * POS_W;
    localparam logic [1:0] ROW_NONE = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD_ROW   = 2'd0,
        OP_LOAD_POINT = 2'd1,
        OP_REBUILD    = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_MAC
    } state_t;

    typedef struct packed {
        logic div_start;
        logic mac_start;
    } lane_ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic mac_busy;
    } lane_status_t;

endpackage

FILE: hdl/affine_point_delta_decoder_unit.sv
// ----------------------------------------------------------------------------
// affine_point_delta_decoder_unit
// Rebuilds 3-D points of one group from previous positions, a 3x3 Q-format
// matrix, the old mean and a new centre.
// ----------------------------------------------------------------------------
// Transform-row and point-load transactions never raise busy. A rebuild
// with the mean cached runs from start to the done strobe through one store
// read, one difference stage, three multiplies through each lane's single
// multiplier plus two pipeline stages, then the output register. After any
// point load the first rebuild also runs the bit-serial mean divider (41
// quotient bits) before the difference stage. A rebuild of an empty group
// answers on the next cycle. Results come out on a one-cycle done strobe and
// cannot be held off; a new start is taken in the same cycle done shows.
module affine_point_delta_decoder_unit #(
    parameter int MAX_POINTS           = apdd_pkg::MAX_POINTS_DEF,
    parameter int MATRIX_FRACTION_BITS = apdd_pkg::MFB_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        operation,
    input  logic [1:0]                        row,
    input  logic [apdd_pkg::IDX_W-1:0]        point_index,
    input  logic signed [apdd_pkg::POS_W-1:0] value_a,
    input  logic signed [apdd_pkg::POS_W-1:0] value_b,
    input  logic signed [apdd_pkg::POS_W-1:0] value_c,
    input  logic signed [apdd_pkg::POS_W-1:0] centre_value,
    input  logic                              raw_a,
    input  logic                              raw_b,
    input  logic                              raw_c,
    output logic                              done,
    output logic signed [apdd_pkg::POS_W-1:0] pos_x,
    output logic signed [apdd_pkg::POS_W-1:0] pos_y,
    output logic signed [apdd_pkg::POS_W-1:0] pos_z,
    output logic                              empty_group
);
    import apdd_pkg::*;

    localparam logic signed [POS_W-1:0] ONE_Q =
        POS_W'(64'(1) << MATRIX_FRACTION_BITS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(33'sh0_8000_0000);

    state_t state_reg, state_next;
    logic   accept;
    op_t    op;

    logic signed [POS_W-1:0] vin [3];
    logic signed [POS_W-1:0] mat_reg [9];
    logic signed [POS_W-1:0] centre_reg [3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0]        count_reg;
    logic                    mean_ready_reg;
    logic signed [POS_W-1:0] val_reg [3];
    logic [2:0]              raw_reg;
    logic signed [DIFF_W-1:0] d_reg [3];

    logic [CNT_W-1:0]        base_count;
    logic                    load_ok;
    logic                    is_load, is_rebuild, is_empty;

    logic [STORE_W-1:0]      rdata;
    logic signed [POS_W-1:0] prev [3];

    lane_ctrl_t              ctrl;
    lane_status_t            stat [3];
    logic signed [POS_W-1:0] mean [3];
    logic signed [ACC_W-1:0] acc [3];
    logic                    div_busy, mac_busy, finish;

    logic signed [POS_W-1:0] pos_reg [3];
    logic                    empty_reg, done_reg;

    assign vin[0] = value_a;
    assign vin[1] = value_b;
    assign vin[2] = value_c;

    assign op         = op_t'(operation);
    assign accept     = start & ~busy;
    assign is_load    = accept && (op == OP_LOAD_POINT);
    assign is_rebuild = accept && (op == OP_REBUILD);
    assign is_empty   = is_rebuild && (count_reg == '0);
    assign base_count = (point_index == '0) ? '0 : count_reg;
    assign load_ok    = ({1'b0, point_index} < CNT_W'(MAX_POINTS))
                        && (base_count < CNT_W'(MAX_POINTS));

    apdd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (is_load & load_ok),
        .re    (is_rebuild),
        .addr  (point_index),
        .wdata ({value_c, value_b, value_a}),
        .rdata (rdata)
    );

    assign prev[0] = rdata[POS_W-1:0];
    assign prev[1] = rdata[2*POS_W-1:POS_W];
    assign prev[2] = rdata[3*POS_W-1:2*POS_W];

    genvar j;
    generate
        for (j = 0; j < 3; j++)
        begin : g_lane
            logic signed [POS_W-1:0] coef [3];
            assign coef[0] = mat_reg[3*j];
            assign coef[1] = mat_reg[3*j+1];
            assign coef[2] = mat_reg[3*j+2];

            apdd_lane #(
                .MATRIX_FRACTION_BITS (MATRIX_FRACTION_BITS)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .status (stat[j]),
                .sum    (sum_reg[j]),
                .count  (count_reg),
                .coef   (coef),
                .diff   (d_reg),
                .centre (centre_reg[j]),
                .corr   (val_reg[j]),
                .mean   (mean[j]),
                .acc    (acc[j])
            );
        end
    endgenerate

    assign div_busy = stat[0].div_busy | stat[1].div_busy | stat[2].div_busy;
    assign mac_busy = stat[0].mac_busy | stat[1].mac_busy | stat[2].mac_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_rebuild && !is_empty)
                begin
                    state_next = mean_ready_reg ? ST_DIFF : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctrl.div_start = 1'b0;
        ctrl.mac_start = 1'b0;
        finish         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.div_start = is_rebuild && !is_empty && !mean_ready_reg;
            end
            ST_DIFF:
            begin
                ctrl.mac_start = 1'b1;
            end
            ST_MAC:
            begin
                finish = !mac_busy;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            mean_ready_reg <= 1'b0;
            done_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]    <= '0;
                centre_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= (i % 4 == 0) ? ONE_Q : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= is_empty | finish;
            if (state_reg == ST_DIV && !div_busy)
            begin
                mean_ready_reg <= 1'b1;
            end
            if (accept && op == OP_LOAD_ROW && row != ROW_NONE)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mat_reg[3*row + i] <= vin[i];
                end
                centre_reg[row] <= centre_value;
            end
            if (is_load)
            begin
                mean_ready_reg <= 1'b0;
                count_reg      <= load_ok ? base_count + CNT_W'(1) : base_count;
                for (int i = 0; i < 3; i++)
                begin
                    if (point_index == '0)
                    begin
                        sum_reg[i] <= load_ok ? SUM_W'(vin[i]) : '0;
                    end
                    else if (load_ok)
                    begin
                        sum_reg[i] <= sum_reg[i] + SUM_W'(vin[i]);
                    end
                end
            end
        end
    end

    // transaction payload and merged result
    always_ff @(posedge clk)
    begin
        if (is_rebuild)
        begin
            for (int i = 0; i < 3; i++)
            begin
                val_reg[i] <= vin[i];
            end
            raw_reg <= {raw_c, raw_b, raw_a};
        end
        if (state_reg == ST_DIFF)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= DIFF_W'(prev[i]) - DIFF_W'(mean[i]);
            end
        end
        if (is_empty)
        begin
            empty_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (finish)
        begin
            empty_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                if (raw_reg[i])
                begin
                    pos_reg[i] <= val_reg[i];
                end
                else if (acc[i] > SAT_HI)
                begin
                    pos_reg[i] <= SAT_HI[POS_W-1:0];
                end
                else if (acc[i] < SAT_LO)
                begin
                    pos_reg[i] <= SAT_LO[POS_W-1:0];
                end
                else
                begin
                    pos_reg[i] <= acc[i][POS_W-1:0];
                end
            end
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign pos_x       = pos_reg[0];
    assign pos_y       = pos_reg[1];
    assign pos_z       = pos_reg[2];
    assign empty_group = empty_reg;

`include "affine_point_delta_decoder_unit_defines.svh"

    `APDD_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while sequencer busy")
    `APDD_ASSERT_SAME(a_empty_zero, done && empty_group,
        pos_x == '0 && pos_y == '0 && pos_z == '0, "empty group result not zero")
    `APDD_ASSERT_NEXT(a_rebuild_progress, start && !busy && operation == OP_REBUILD,
        done || busy, "rebuild transaction dropped")
    `APDD_ASSERT_SAME(a_mac_mean, state_reg == ST_MAC, mean_ready_reg,
        "multiply started without a valid mean")

endmodule

FILE: hdl/apdd_ram.sv
// ----------------------------------------------------------------------------
// apdd_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module apdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/apdd_lane.sv
// ----------------------------------------------------------------------------
// apdd_lane
// One coordinate lane: serial mean divider and a multiply-round-accumulate
// over one matrix row.
// ----------------------------------------------------------------------------
module apdd_lane #(
    parameter int MATRIX_FRACTION_BITS = apdd_pkg::MFB_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  apdd_pkg::lane_ctrl_t                  ctrl,
    output apdd_pkg::lane_status_t                status,
    input  logic signed [apdd_pkg::SUM_W-1:0]     sum,
    input  logic [apdd_pkg::CNT_W-1:0]            count,
    input  logic signed [apdd_pkg::POS_W-1:0]     coef [3],
    input  logic signed [apdd_pkg::DIFF_W-1:0]    diff [3],
    input  logic signed [apdd_pkg::POS_W-1:0]     centre,
    input  logic signed [apdd_pkg::POS_W-1:0]     corr,
    output logic signed [apdd_pkg::POS_W-1:0]     mean,
    output logic signed [apdd_pkg::ACC_W-1:0]     acc
);
    import apdd_pkg::*;

    localparam logic [PROD_W-2:0] HALF = (PROD_W-1)'(1) << (MATRIX_FRACTION_BITS - 1);

    // divider
    logic                    div_busy_reg, div_busy_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        den_reg;
    logic                    neg_reg;
    logic signed [POS_W-1:0] mean_reg, mean_next;
    logic signed [DVD_W-1:0] sum_ext;
    logic [DVD_W-1:0]        sum_mag;
    logic [REM_W-1:0]        rem_shift;
    logic                    ge;

    assign sum_ext   = DVD_W'(sum);
    assign sum_mag   = sum_ext[DVD_W-1] ? DVD_W'(-sum_ext) : DVD_W'(sum_ext);
    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign ge        = rem_shift >= REM_W'(den_reg);

    always_comb
    begin
        div_busy_next = div_busy_reg;
        step_next     = step_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        mean_next     = mean_reg;
        if (ctrl.div_start)
        begin
            div_busy_next = 1'b1;
            step_next     = STEP_W'(DVD_W - 1);
            dvd_next      = sum_mag + DVD_W'(count >> 1);
            rem_next      = '0;
        end
        else if (div_busy_reg)
        begin
            rem_next = ge ? rem_shift - REM_W'(den_reg) : rem_shift;
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                div_busy_next = 1'b0;
                mean_next = neg_reg ? -$signed(dvd_next[POS_W-1:0])
                                    : $signed(dvd_next[POS_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            div_busy_reg <= div_busy_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        mean_reg <= mean_next;
        if (ctrl.div_start)
        begin
            den_reg <= count;
            neg_reg <= sum[SUM_W-1];
        end
    end

    // multiply, round, accumulate
    logic                     issue_reg, issue_next;
    logic                     v1_reg, v2_reg;
    logic [1:0]               k_reg, k_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [RP_W-1:0]   rp_reg, rp_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-2:0]        pmag, rmag;

    assign prod_next = PROD_W'(coef[k_reg]) * PROD_W'(diff[k_reg]);
    assign pmag      = prod_reg[PROD_W-1] ? (PROD_W-1)'(-prod_reg) : prod_reg[PROD_W-2:0];
    assign rmag      = (pmag + HALF) >> MATRIX_FRACTION_BITS;
    assign rp_next   = prod_reg[PROD_W-1] ? -$signed(RP_W'(rmag)) : $signed(RP_W'(rmag));

    always_comb
    begin
        issue_next = issue_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        if (ctrl.mac_start)
        begin
            issue_next = 1'b1;
            k_next     = 2'd0;
            acc_next   = ACC_W'(centre) + ACC_W'(corr);
        end
        else
        begin
            if (issue_reg)
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    issue_next = 1'b0;
                end
            end
            if (v2_reg)
            begin
                acc_next = acc_reg + ACC_W'(rp_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            k_reg     <= 2'd0;
        end
        else
        begin
            issue_reg <= issue_next;
            v1_reg    <= issue_reg;
            v2_reg    <= v1_reg;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rp_reg   <= rp_next;
        acc_reg  <= acc_next;
    end

    assign status.div_busy = div_busy_reg;
    assign status.mac_busy = issue_reg | v1_reg | v2_reg;
    assign mean = mean_reg;
    assign acc  = acc_reg;

endmodule

FILE: tb/sv/affine_point_delta_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_delta_decoder_unit_tb
// Drives transform, load and rebuild transactions into the decoder, predicts
// every rebuilt point with a behavioral model and checks it field by field.
// ----------------------------------------------------------------------------
module affine_point_delta_decoder_unit_tb;
    import apdd_pkg::*;

    localparam int MAXP = MAX_POINTS_DEF;
    localparam int MFB  = MFB_DEF;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               empty;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] operation = OP_NONE;
    logic [1:0] row = '0;
    logic [7:0] point_index = '0;
    logic signed [31:0] value_a = '0, value_b = '0, value_c = '0, centre_value = '0;
    logic raw_a = 1'b0, raw_b = 1'b0, raw_c = 1'b0;
    logic done;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic empty_group;

    always #6 clk = ~clk;

    affine_point_delta_decoder_unit dut (.*);

    // model state
    logic signed [31:0] m_px [256];
    logic signed [31:0] m_py [256];
    logic signed [31:0] m_pz [256];
    bit                 m_written [256];
    longint             m_sum [3];
    int                 m_count;
    logic signed [31:0] m_mat [9];
    logic signed [31:0] m_centre [3];
    logic signed [31:0] m_mean [3];
    bit                 m_mean_ok;

    point_t expected_points [$];
    int     errors = 0;
    int     mismatches = 0;
    int     checked = 0;
    int     sent = 0;
    bit     quiet = 1'b0;

    function automatic logic signed [31:0] round_div(longint s, int c);
        longint unsigned m, q;
        m = (s < 0) ? -s : s;
        q = (m + c / 2) / c;
        return (s < 0) ? 32'(-longint'(q)) : 32'(longint'(q));
    endfunction

    function automatic longint round_mul(longint a, longint d);
        longint unsigned u, r;
        u = ((a < 0) ? -a : a) * ((d < 0) ? -d : d);
        r = (u + (64'd1 << (MFB - 1))) >> MFB;
        return ((a < 0) != (d < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic reset_model();
        for (int i = 0; i < 9; i++)
            m_mat[i] = (i % 4 == 0) ? (32'sd1 <<< MFB) : 32'sd0;
        for (int i = 0; i < 3; i++)
        begin
            m_sum[i] = 0;
            m_centre[i] = 0;
            m_mean[i] = 0;
        end
        for (int i = 0; i < 256; i++)
            m_written[i] = 1'b0;
        m_count = 0;
        m_mean_ok = 1'b0;
    endtask

    task automatic predict_point(logic [1:0] op, logic [1:0] r, logic [7:0] idx,
                                 logic signed [31:0] a, b, c, cv,
                                 logic ra, rb, rc);
        longint v [3];
        longint d [3];
        longint acc;
        logic   rw [3];
        logic signed [31:0] res [3];
        point_t p;
        v[0] = longint'(a); v[1] = longint'(b); v[2] = longint'(c);
        rw[0] = ra; rw[1] = rb; rw[2] = rc;
        if (op == OP_LOAD_ROW)
        begin
            if (r != ROW_NONE)
            begin
                for (int j = 0; j < 3; j++)
                    m_mat[r * 3 + j] = 32'(v[j]);
                m_centre[r] = cv;
            end
        end
        else if (op == OP_LOAD_POINT)
        begin
            m_mean_ok = 1'b0;
            if (idx == 0)
            begin
                for (int j = 0; j < 3; j++)
                    m_sum[j] = 0;
                m_count = 0;
            end
            if (idx < MAXP && m_count < MAXP)
            begin
                m_px[idx] = a; m_py[idx] = b; m_pz[idx] = c;
                m_written[idx] = 1'b1;
                for (int j = 0; j < 3; j++)
                    m_sum[j] += v[j];
                m_count++;
            end
        end
        else if (op == OP_REBUILD)
        begin
            if (m_count == 0)
            begin
                p = '{x: 0, y: 0, z: 0, empty: 1'b1};
            end
            else
            begin
                if (!m_mean_ok)
                begin
                    for (int j = 0; j < 3; j++)
                        m_mean[j] = round_div(m_sum[j], m_count);
                    m_mean_ok = 1'b1;
                end
                d[0] = longint'(m_px[idx]) - longint'(m_mean[0]);
                d[1] = longint'(m_py[idx]) - longint'(m_mean[1]);
                d[2] = longint'(m_pz[idx]) - longint'(m_mean[2]);
                for (int j = 0; j < 3; j++)
                begin
                    if (rw[j])
                        res[j] = 32'(v[j]);
                    else
                    begin
                        acc = longint'(m_centre[j]) + v[j];
                        for (int k = 0; k < 3; k++)
                            acc += round_mul(longint'(m_mat[j * 3 + k]), d[k]);
                        res[j] = clamp32(acc);
                    end
                end
                p = '{x: res[0], y: res[1], z: res[2], empty: 1'b0};
            end
            expected_points = {expected_points, p};
        end
    endtask

    task automatic send_item(logic [1:0] op, logic [1:0] r, logic [7:0] idx,
                             logic signed [31:0] a, b, c, cv,
                             logic ra, rb, rc);
        while (!quiet && $urandom_range(99) < 12)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op; row <= r; point_index <= idx;
        value_a <= a; value_b <= b; value_c <= c; centre_value <= cv;
        raw_a <= ra; raw_b <= rb; raw_c <= rc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted by now: predict before the checker samples the strobe
        predict_point(op, r, idx, a, b, c, cv, ra, rb, rc);
        sent++;
    endtask

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_entry();
        case ($urandom_range(3))
            0: return 32'sd1 <<< MFB;
            1: return $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
            2: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // rebuild index restricted to written entries
    function automatic logic [7:0] written_idx(int n);
        logic [7:0] k;
        k = 8'($urandom_range(n - 1));
        if (!m_written[k]) k = 0;
        return k;
    endfunction

    task automatic test_directed();
        send_item(OP_REBUILD, 0, 0, 5, 6, 7, 0, 1, 1, 1);             // empty group
        send_item(OP_LOAD_POINT, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0);
        send_item(OP_LOAD_POINT, 0, 1, 32'sh80000000, 32'sh7fffffff, -1, 0, 0, 0, 0);
        send_item(OP_LOAD_POINT, 0, 1, 3, -3, 1, 0, 0, 0, 0);          // repeated index
        send_item(OP_LOAD_POINT, 0, 255, 9, 9, 9, 0, 0, 0, 0);         // out of range
        send_item(OP_REBUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_REBUILD, 0, 1, 32'sh7fffffff, 32'sh80000000, 1, 0, 0, 0, 0);
        send_item(OP_LOAD_ROW, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff,
                  0, 0, 0);
        send_item(OP_LOAD_ROW, 1, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh80000000, 0, 0, 0);
        send_item(OP_LOAD_ROW, 2, 0, -1, 1, 32'sh80000000, 12345, 0, 0, 0);
        send_item(OP_LOAD_ROW, ROW_NONE, 0, 1, 1, 1, 1, 0, 0, 0);     // unused row
        send_item(OP_NONE, 2, 3, 4, 5, 6, 7, 1, 1, 1);                 // unused op
        send_item(OP_REBUILD, 0, 0, 32'sh7fffffff, 32'sh80000000, 5, 0, 0, 0, 0);
        send_item(OP_REBUILD, 0, 1, 32'sh7fffffff, 32'sh80000000, -5, 0, 1, 0, 1);
        send_item(OP_REBUILD, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();
    endtask

    task automatic test_full_group();
        for (int i = 0; i < 256; i++)
            send_item(OP_LOAD_POINT, 0, i[7:0], rnd32(), rnd32(), rnd32(), 0, 0, 0, 0);
        // group full: this load is dropped
        send_item(OP_LOAD_POINT, 0, 7, 1, 2, 3, 0, 0, 0, 0);
        send_item(OP_REBUILD, 0, 254, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_REBUILD, 0, 7, 1, -1, 0, 0, 0, 1, 0);
        wait_idle();
    endtask

    task automatic test_random();
        int n;
        n = 4;
        for (int i = 0; i < 560; i++)
        begin
            quiet = (i >= 250 && i < 350);
            case ($urandom_range(9))
                0: send_item(OP_LOAD_ROW, 2'($urandom_range(3)), 8'($urandom),
                             rnd_entry(), rnd_entry(), rnd_entry(), rnd32(),
                             1'($urandom), 1'($urandom), 1'($urandom));
                1, 2:
                begin
                    if ($urandom_range(5) == 0)
                    begin
                        n = $urandom_range(1, 12);
                        for (int k = 0; k < n; k++)
                            send_item(OP_LOAD_POINT, 0, k[7:0], rnd32(), rnd32(),
                                      rnd32(), $urandom, 0, 0, 0);
                    end
                    else
                        send_item(OP_LOAD_POINT, 2'($urandom), 8'($urandom_range(1, 255)),
                                  rnd32(), rnd32(), rnd32(), $urandom, 0, 0, 0);
                end
                3: send_item(OP_NONE, 2'($urandom), 8'($urandom), rnd32(), rnd32(),
                             rnd32(), rnd32(), 1'($urandom), 1'($urandom),
                             1'($urandom));
                default: send_item(OP_REBUILD, 2'($urandom), written_idx(n), rnd32(),
                                   rnd32(), rnd32(), rnd32(), $urandom_range(3) == 0,
                                   $urandom_range(3) == 0, $urandom_range(3) == 0);
            endcase
        end
        quiet = 1'b0;
        wait_idle();
    endtask

    // result checker
    always @(posedge clk)
    begin
        point_t e;
        if (done)
        begin
            if (expected_points.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result %0d %0d %0d %0b", pos_x, pos_y, pos_z,
                             empty_group);
            end
            else
            begin
                e = expected_points.pop_front();
                checked++;
                if (pos_x !== e.x || pos_y !== e.y || pos_z !== e.z
                    || empty_group !== e.empty)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                 e.x, e.y, e.z, e.empty, pos_x, pos_y, pos_z,
                                 empty_group);
                end
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_group();
        test_random();
        if (expected_points.size() != 0)
            errors++;
        $display("Sent %0d transactions, checked %0d rebuilt points.", sent, checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
